// ===== design/pixel_depth_deprojection_core_defines.svh =====
`ifndef PIXEL_DEPTH_DEPROJECTION_CORE_DEFINES_SVH
`define PIXEL_DEPTH_DEPROJECTION_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PDD_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PDD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/pdd_pkg.sv =====
`default_nettype none

package pdd_pkg;

   typedef enum logic [2:0] {
      REG_PRINCIPAL_POINT = 3'd0,
      REG_INV_FOCAL_X     = 3'd1,
      REG_INV_FOCAL_Y     = 3'd2,
      REG_RADIAL_K1       = 3'd3,
      REG_RADIAL_K2       = 3'd4,
      REG_RADIAL_K3       = 3'd5,
      REG_TANGENTIAL_P1   = 3'd6,
      REG_TANGENTIAL_P2   = 3'd7
   } reg_index_type;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int PP_BITS       = 16;
   localparam int FOCAL_BITS    = 24;
   localparam int COEF_BITS     = 24;
   localparam int NORM_BITS     = 23;
   localparam int FACT_BITS     = 32;
   localparam int OUT_BITS      = 24;
   localparam int Z_BITS        = 16;
   localparam int RSP_BITS      = 2 * OUT_BITS + Z_BITS;

   // register stages from the input register to the last product
   localparam int PIPE_STAGES   = 17;

   localparam logic signed [NORM_BITS-1:0] NORM_MAX = 23'sh3F_FFFF;
   localparam logic signed [NORM_BITS-1:0] NORM_MIN = 23'sh40_0000;
   localparam logic signed [FACT_BITS-1:0] FACT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [FACT_BITS-1:0] FACT_MIN = 32'sh8000_0000;
   localparam logic signed [OUT_BITS-1:0]  OUT_MAX  = 24'sh7F_FFFF;
   localparam logic signed [OUT_BITS-1:0]  OUT_MIN  = 24'sh80_0000;
   localparam logic [Z_BITS-1:0]           Z_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [PP_BITS-1:0]           ppx;
      logic [PP_BITS-1:0]           ppy;
      logic [FOCAL_BITS-1:0]        ifx;
      logic [FOCAL_BITS-1:0]        ify;
      logic signed [COEF_BITS-1:0]  k1;
      logic signed [COEF_BITS-1:0]  k2;
      logic signed [COEF_BITS-1:0]  k3;
      logic signed [COEF_BITS-1:0]  p1;
      logic signed [COEF_BITS-1:0]  p2;
   } cfg_type;

   typedef struct packed {
      logic en;         // whole pipeline advances
      logic push;       // last stage hands an item to the output buffer
      logic load_out;   // new item goes straight to the output register
      logic load_skid;  // new item parks in the skid register
      logic move_skid;  // skid item moves up to the output register
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// ===== design/pdd_pipe_ctrl.sv =====
`default_nettype none

`include "pixel_depth_deprojection_core_defines.svh"

module pdd_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  rsp_tready,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   output pdd_pkg::pipe_ctrl_type ctrl
);

   localparam int STAGES = pdd_pkg::PIPE_STAGES;

   logic [STAGES-1:0] v_ff, v_in;
   logic              out_v_ff, out_v_in;
   logic              skid_v_ff, skid_v_in;
   logic              en, pop, push, load_out, load_skid, move_skid;

   always_comb begin
      // skid state is registered, so ready never depends on rsp_tready
      en        = !skid_v_ff;
      pop       = out_v_ff & rsp_tready;
      push      = en & v_ff[STAGES-1];
      load_out  = push & (!out_v_ff | pop);
      load_skid = push & out_v_ff & !pop;
      move_skid = skid_v_ff & pop;
      v_in      = en ? {v_ff[STAGES-2:0], req_tvalid} : v_ff;
      out_v_in  = (out_v_ff & !pop) | push | skid_v_ff;
      skid_v_in = load_skid | (skid_v_ff & !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         v_ff      <= v_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   assign req_tready     = en;
   assign rsp_tvalid     = out_v_ff;
   assign ctrl.en        = en;
   assign ctrl.push      = push;
   assign ctrl.load_out  = load_out;
   assign ctrl.load_skid = load_skid;
   assign ctrl.move_skid = move_skid;

   `PDD_ASSERT_SAME(a_skid_implies_out, clock, reset, skid_v_ff, out_v_ff, "skid item without output item")
   `PDD_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !en, $stable(v_ff), "pipeline moved while stalled")
   `PDD_ASSERT_NEXT(a_blocked_push_parks, clock, reset, push && out_v_ff && !rsp_tready, skid_v_ff, "blocked item was not parked")
   `PDD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_v_ff && rsp_tready, out_v_ff && !skid_v_ff, "skid item not moved up")

endmodule

`default_nettype wire

// ===== design/pdd_normalize.sv =====
`default_nettype none

module pdd_normalize #(
   parameter int COORD_BITS = 12,
   parameter int DEPTH_BITS = 16
) (
   input  logic                                 clock,
   input  pdd_pkg::pipe_ctrl_type               ctrl,
   input  pdd_pkg::cfg_type                     cfg,
   input  logic [COORD_BITS-1:0]                pixel_col,
   input  logic [COORD_BITS-1:0]                pixel_row,
   input  logic [DEPTH_BITS-1:0]                depth_mm,
   output logic signed [pdd_pkg::NORM_BITS-1:0] norm_x,
   output logic signed [pdd_pkg::NORM_BITS-1:0] norm_y,
   output logic [DEPTH_BITS-1:0]                depth
);

   localparam int NB = pdd_pkg::NORM_BITS;
   // offset coordinate in Q.4, signed
   localparam int DW = ((COORD_BITS + 4 > pdd_pkg::PP_BITS) ? COORD_BITS + 4
                                                              : pdd_pkg::PP_BITS) + 1;
   localparam int PW = DW + pdd_pkg::FOCAL_BITS + 1;
   localparam logic signed [PW-1:0] HALF = PW'(128);

   logic signed [DW-1:0]                  dx_ff, dy_ff, dx_in, dy_in;
   logic signed [pdd_pkg::FOCAL_BITS:0]   ifx_s, ify_s;
   logic signed [PW-1:0]                  px_ff, py_ff, px_in, py_in;
   logic signed [PW-1:0]                  rx, ry, qx, qy;
   logic signed [NB-1:0]                  x_ff, y_ff, x_in, y_in;
   logic [DEPTH_BITS-1:0]                 depth_ff [3];

   always_comb begin
      dx_in = DW'({pixel_col, 4'b0000}) - DW'(cfg.ppx);
      dy_in = DW'({pixel_row, 4'b0000}) - DW'(cfg.ppy);
      ifx_s = {1'b0, cfg.ifx};
      ify_s = {1'b0, cfg.ify};
      px_in = dx_ff * ifx_s;
      py_in = dy_ff * ify_s;
      // Q.28 to Q2.20, round half up
      rx    = px_ff + HALF;
      ry    = py_ff + HALF;
      qx    = rx >>> 8;
      qy    = ry >>> 8;
      x_in  = (qx > pdd_pkg::NORM_MAX) ? pdd_pkg::NORM_MAX :
              (qx < pdd_pkg::NORM_MIN) ? pdd_pkg::NORM_MIN : qx[NB-1:0];
      y_in  = (qy > pdd_pkg::NORM_MAX) ? pdd_pkg::NORM_MAX :
              (qy < pdd_pkg::NORM_MIN) ? pdd_pkg::NORM_MIN : qy[NB-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         depth_ff[0] <= depth_mm;
         px_ff       <= px_in;
         py_ff       <= py_in;
         depth_ff[1] <= depth_ff[0];
         x_ff        <= x_in;
         y_ff        <= y_in;
         depth_ff[2] <= depth_ff[1];
      end
   end

   assign norm_x = x_ff;
   assign norm_y = y_ff;
   assign depth  = depth_ff[2];

endmodule

`default_nettype wire

// ===== design/pdd_radial.sv =====
`default_nettype none

module pdd_radial #(
   parameter int DEPTH_BITS = 16
) (
   input  logic                                 clock,
   input  pdd_pkg::pipe_ctrl_type               ctrl,
   input  pdd_pkg::cfg_type                     cfg,
   input  logic signed [pdd_pkg::NORM_BITS-1:0] norm_x,
   input  logic signed [pdd_pkg::NORM_BITS-1:0] norm_y,
   input  logic [DEPTH_BITS-1:0]                depth_i,
   output logic signed [pdd_pkg::NORM_BITS-1:0] x_o,
   output logic signed [pdd_pkg::NORM_BITS-1:0] y_o,
   output logic signed [25:0]                   xy_o,
   output logic signed [27:0]                   tx_o,
   output logic signed [27:0]                   ty_o,
   output logic signed [pdd_pkg::FACT_BITS-1:0] fact_o,
   output logic [DEPTH_BITS-1:0]                depth_o
);

   localparam int NB    = pdd_pkg::NORM_BITS;
   localparam int CB    = pdd_pkg::COEF_BITS;
   localparam int STG   = 10;
   localparam int SQ_W  = 2 * NB;
   localparam int Q_W   = 26;
   localparam int R2_W  = 27;
   localparam int T_W   = 28;
   localparam int M4_W  = 2 * R2_W;
   localparam int R4_W  = 32;
   localparam int M6_W  = R4_W + R2_W;
   localparam int R6_W  = 37;
   localparam int SPLIT = 18;
   localparam int H_W   = R6_W - SPLIT;
   localparam int T1_W  = CB + R2_W;
   localparam int T2_W  = CB + R4_W;
   localparam int T3_W  = CB + H_W;
   localparam int SUM_W = 62;

   localparam logic signed [SQ_W-1:0]  H_SQ   = SQ_W'(1) <<< 19;
   localparam logic signed [M4_W-1:0]  H_M4   = M4_W'(1) <<< 19;
   localparam logic signed [M6_W-1:0]  H_M6   = M6_W'(1) <<< 19;
   // one in Q40 plus the rounding half of the Q40 to Q20 step
   localparam logic signed [SUM_W-1:0] F_BIAS = (SUM_W'(1) <<< 40) + (SUM_W'(1) <<< 19);

   // aligned copies that ride along with each stage
   logic signed [NB-1:0]   x_ff [STG];
   logic signed [NB-1:0]   y_ff [STG];
   logic [DEPTH_BITS-1:0]  depth_ff [STG];
   logic signed [Q_W-1:0]  xy_ff [1:STG-1];
   logic signed [T_W-1:0]  tx_ff [2:STG-1];
   logic signed [T_W-1:0]  ty_ff [2:STG-1];
   logic signed [R2_W-1:0] r2_ff [2:6];
   logic signed [R4_W-1:0] r4_ff [4:6];

   logic signed [SQ_W-1:0]  mxx_ff, myy_ff, mxy_ff, mxx_in, myy_in, mxy_in;
   logic signed [SQ_W-1:0]  sxx, syy, sxy, qxx, qyy, qxy;
   logic signed [Q_W-1:0]   xx_ff, yy_ff, xx_in, yy_in, xy_in;
   logic signed [T_W-1:0]   xx_w, yy_w, tx_in, ty_in;
   logic signed [R2_W-1:0]  r2_in;
   logic signed [M4_W-1:0]  m4_ff, m4_in, s4, q4;
   logic signed [R4_W-1:0]  r4_in;
   logic signed [M6_W-1:0]  m6_ff, m6_in, s6, q6;
   logic signed [R6_W-1:0]  r6_ff, r6_in;
   logic signed [H_W-1:0]   r6_lo, r6_hi;
   logic signed [T1_W-1:0]  t1_ff, t1_in;
   logic signed [T2_W-1:0]  t2_ff, t2_in;
   logic signed [T3_W-1:0]  t3lo_ff, t3hi_ff, t3lo_in, t3hi_in;
   logic signed [SUM_W-1:0] t1_w, t2_w, t3lo_w, t3hi_w;
   logic signed [SUM_W-1:0] sa_ff, sb_ff, sa_in, sb_in, fs, fq;
   logic signed [pdd_pkg::FACT_BITS-1:0] f_ff, f_in;

   always_comb begin
      mxx_in  = norm_x * norm_x;
      myy_in  = norm_y * norm_y;
      mxy_in  = norm_x * norm_y;

      sxx     = mxx_ff + H_SQ;
      syy     = myy_ff + H_SQ;
      sxy     = mxy_ff + H_SQ;
      qxx     = sxx >>> 20;
      qyy     = syy >>> 20;
      qxy     = sxy >>> 20;
      xx_in   = qxx[Q_W-1:0];
      yy_in   = qyy[Q_W-1:0];
      xy_in   = qxy[Q_W-1:0];

      // r2 and the tangential terms r2 + 2*xx, r2 + 2*yy
      xx_w    = xx_ff;
      yy_w    = yy_ff;
      r2_in   = R2_W'(xx_w + yy_w);
      tx_in   = (xx_w <<< 1) + xx_w + yy_w;
      ty_in   = (yy_w <<< 1) + yy_w + xx_w;

      m4_in   = r2_ff[2] * r2_ff[2];
      s4      = m4_ff + H_M4;
      q4      = s4 >>> 20;
      r4_in   = q4[R4_W-1:0];

      m6_in   = r4_ff[4] * r2_ff[4];
      s6      = m6_ff + H_M6;
      q6      = s6 >>> 20;
      r6_in   = q6[R6_W-1:0];

      // k3 * r6 is taken in two halves of r6
      r6_lo   = {1'b0, r6_ff[SPLIT-1:0]};
      r6_hi   = r6_ff[R6_W-1:SPLIT];
      t1_in   = cfg.k1 * r2_ff[6];
      t2_in   = cfg.k2 * r4_ff[6];
      t3lo_in = cfg.k3 * r6_lo;
      t3hi_in = cfg.k3 * r6_hi;

      t1_w    = t1_ff;
      t2_w    = t2_ff;
      t3lo_w  = t3lo_ff;
      t3hi_w  = t3hi_ff;
      sa_in   = t1_w + t2_w + F_BIAS;
      sb_in   = t3lo_w + (t3hi_w <<< SPLIT);

      fs      = sa_ff + sb_ff;
      fq      = fs >>> 20;
      f_in    = (fq > pdd_pkg::FACT_MAX) ? pdd_pkg::FACT_MAX :
                (fq < pdd_pkg::FACT_MIN) ? pdd_pkg::FACT_MIN :
                fq[pdd_pkg::FACT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         x_ff[0]     <= norm_x;
         y_ff[0]     <= norm_y;
         depth_ff[0] <= depth_i;
         for (int i = 1; i < STG; i++) begin
            x_ff[i]     <= x_ff[i-1];
            y_ff[i]     <= y_ff[i-1];
            depth_ff[i] <= depth_ff[i-1];
         end
         xy_ff[1] <= xy_in;
         for (int i = 2; i < STG; i++) begin
            xy_ff[i] <= xy_ff[i-1];
         end
         tx_ff[2] <= tx_in;
         ty_ff[2] <= ty_in;
         for (int i = 3; i < STG; i++) begin
            tx_ff[i] <= tx_ff[i-1];
            ty_ff[i] <= ty_ff[i-1];
         end
         r2_ff[2] <= r2_in;
         for (int i = 3; i < 7; i++) begin
            r2_ff[i] <= r2_ff[i-1];
         end
         r4_ff[4] <= r4_in;
         for (int i = 5; i < 7; i++) begin
            r4_ff[i] <= r4_ff[i-1];
         end
         mxx_ff  <= mxx_in;
         myy_ff  <= myy_in;
         mxy_ff  <= mxy_in;
         xx_ff   <= xx_in;
         yy_ff   <= yy_in;
         m4_ff   <= m4_in;
         m6_ff   <= m6_in;
         r6_ff   <= r6_in;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         t3lo_ff <= t3lo_in;
         t3hi_ff <= t3hi_in;
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         f_ff    <= f_in;
      end
   end

   assign x_o     = x_ff[STG-1];
   assign y_o     = y_ff[STG-1];
   assign xy_o    = xy_ff[STG-1];
   assign tx_o    = tx_ff[STG-1];
   assign ty_o    = ty_ff[STG-1];
   assign fact_o  = f_ff;
   assign depth_o = depth_ff[STG-1];

endmodule

`default_nettype wire

// ===== design/pdd_correct.sv =====
`default_nettype none

module pdd_correct #(
   parameter int DEPTH_BITS = 16
) (
   input  logic                                 clock,
   input  pdd_pkg::pipe_ctrl_type               ctrl,
   input  pdd_pkg::cfg_type                     cfg,
   input  logic signed [pdd_pkg::NORM_BITS-1:0] x_i,
   input  logic signed [pdd_pkg::NORM_BITS-1:0] y_i,
   input  logic signed [25:0]                   xy_i,
   input  logic signed [27:0]                   tx_i,
   input  logic signed [27:0]                   ty_i,
   input  logic signed [pdd_pkg::FACT_BITS-1:0] fact_i,
   input  logic [DEPTH_BITS-1:0]                depth_i,
   output logic [pdd_pkg::OUT_BITS-1:0]         point_x,
   output logic [pdd_pkg::OUT_BITS-1:0]         point_y,
   output logic [pdd_pkg::Z_BITS-1:0]           point_z
);

   localparam int NB   = pdd_pkg::NORM_BITS;
   localparam int OB   = pdd_pkg::OUT_BITS;
   localparam int A_W  = NB + pdd_pkg::FACT_BITS;
   localparam int B_W  = pdd_pkg::COEF_BITS + 26;
   localparam int C_W  = pdd_pkg::COEF_BITS + 28;
   localparam int U_W  = 58;
   localparam int MP_W = DEPTH_BITS + 1 + NB;

   localparam logic signed [U_W-1:0]  H_U  = U_W'(1) <<< 19;
   localparam logic signed [MP_W-1:0] H_MP = MP_W'(1) <<< 15;

   typedef struct packed {
      logic [OB-1:0]                  x;
      logic [OB-1:0]                  y;
      logic [pdd_pkg::Z_BITS-1:0]     z;
   } point_type;

   logic signed [A_W-1:0]  ax_ff, ay_ff, ax_in, ay_in;
   logic signed [B_W-1:0]  bx_ff, by_ff, bx_in, by_in;
   logic signed [C_W-1:0]  cx_ff, cy_ff, cx_in, cy_in;
   logic signed [U_W-1:0]  ax_w, ay_w, bx_w, by_w, cx_w, cy_w;
   logic signed [U_W-1:0]  sux_ff, suy_ff, sux_in, suy_in, qux, quy;
   logic signed [NB-1:0]   ux_ff, uy_ff, ux_in, uy_in;
   logic signed [DEPTH_BITS:0] depth_s;
   logic signed [MP_W-1:0] mpx_ff, mpy_ff, mpx_in, mpy_in, rpx, rpy, qpx, qpy;
   logic [DEPTH_BITS-1:0]  depth_ff [4];
   logic [31:0]            depth_wide;
   point_type              res, out_ff, skid_ff;

   always_comb begin
      ax_in  = x_i * fact_i;
      bx_in  = cfg.p1 * xy_i;
      cx_in  = cfg.p2 * tx_i;
      ay_in  = y_i * fact_i;
      by_in  = cfg.p2 * xy_i;
      cy_in  = cfg.p1 * ty_i;

      ax_w   = ax_ff;
      bx_w   = bx_ff;
      cx_w   = cx_ff;
      ay_w   = ay_ff;
      by_w   = by_ff;
      cy_w   = cy_ff;
      sux_in = ax_w + (bx_w <<< 1) + cx_w + H_U;
      suy_in = ay_w + (by_w <<< 1) + cy_w + H_U;

      qux    = sux_ff >>> 20;
      quy    = suy_ff >>> 20;
      ux_in  = (qux > pdd_pkg::NORM_MAX) ? pdd_pkg::NORM_MAX :
               (qux < pdd_pkg::NORM_MIN) ? pdd_pkg::NORM_MIN : qux[NB-1:0];
      uy_in  = (quy > pdd_pkg::NORM_MAX) ? pdd_pkg::NORM_MAX :
               (quy < pdd_pkg::NORM_MIN) ? pdd_pkg::NORM_MIN : quy[NB-1:0];

      depth_s = {1'b0, depth_ff[2]};
      mpx_in  = depth_s * ux_ff;
      mpy_in  = depth_s * uy_ff;

      // mm times Q20 down to 1/16 mm
      rpx   = mpx_ff + H_MP;
      rpy   = mpy_ff + H_MP;
      qpx   = rpx >>> 16;
      qpy   = rpy >>> 16;
      res.x = (qpx > pdd_pkg::OUT_MAX) ? pdd_pkg::OUT_MAX :
              (qpx < pdd_pkg::OUT_MIN) ? pdd_pkg::OUT_MIN : qpx[OB-1:0];
      res.y = (qpy > pdd_pkg::OUT_MAX) ? pdd_pkg::OUT_MAX :
              (qpy < pdd_pkg::OUT_MIN) ? pdd_pkg::OUT_MIN : qpy[OB-1:0];
      depth_wide = 32'(depth_ff[3]);
      res.z = (depth_wide > 32'(pdd_pkg::Z_MAX)) ? pdd_pkg::Z_MAX
                                                 : depth_wide[pdd_pkg::Z_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         ax_ff       <= ax_in;
         bx_ff       <= bx_in;
         cx_ff       <= cx_in;
         ay_ff       <= ay_in;
         by_ff       <= by_in;
         cy_ff       <= cy_in;
         depth_ff[0] <= depth_i;
         sux_ff      <= sux_in;
         suy_ff      <= suy_in;
         depth_ff[1] <= depth_ff[0];
         ux_ff       <= ux_in;
         uy_ff       <= uy_in;
         depth_ff[2] <= depth_ff[1];
         mpx_ff      <= mpx_in;
         mpy_ff      <= mpy_in;
         depth_ff[3] <= depth_ff[2];
      end
      // two-entry output buffer
      if (ctrl.move_skid) begin
         out_ff <= skid_ff;
      end else if (ctrl.load_out) begin
         out_ff <= res;
      end
      if (ctrl.load_skid) begin
         skid_ff <= res;
      end
   end

   assign point_x = out_ff.x;
   assign point_y = out_ff.y;
   assign point_z = out_ff.z;

endmodule

`default_nettype wire

// ===== design/pixel_depth_deprojection_core.sv =====
`default_nettype none

// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  pixel_col, pixel_row, depth_mm
// rsp      out        rsp_tvalid / rsp_tready  point_x, point_y, point_z
// csr      in         csr_we (no wait)         csr_addr, csr_wdata, write only
//
// One item per clock sustained while the second output buffer entry stays free; each
// item goes from acceptance to rsp_tvalid through the input register, loaded at the
// accepting edge, 16 more register stages of the multiplier chain, then the output register.
// Reset is synchronous and clears the valid bits, also those of the output buffer, and all CSRs.
// A stalled result parks in a two-entry output buffer; req_tready falls only
// once its second entry is taken, and the whole pipeline holds while it is low.

module pixel_depth_deprojection_core #(
   parameter int  COORD_BITS = 12,
   parameter int  DEPTH_BITS = 16,
   localparam int REQ_BITS   = ((2 * COORD_BITS + DEPTH_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_BITS-1:0]                   req_tdata,  // pixel_col, pixel_row, depth_mm
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pdd_pkg::RSP_BITS-1:0]          rsp_tdata,  // point_x, point_y, point_z
   input  logic                                  csr_we,
   input  logic [pdd_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [pdd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CB = pdd_pkg::COEF_BITS;

   pdd_pkg::cfg_type       cfg_ff;
   pdd_pkg::pipe_ctrl_type ctrl;

   logic [COORD_BITS-1:0]                 pixel_col, pixel_row;
   logic [DEPTH_BITS-1:0]                 depth_mm, depth_n, depth_r;
   logic signed [pdd_pkg::NORM_BITS-1:0]  norm_x, norm_y, x_r, y_r;
   logic signed [25:0]                    xy_r;
   logic signed [27:0]                    tx_r, ty_r;
   logic signed [pdd_pkg::FACT_BITS-1:0]  fact_r;
   logic [pdd_pkg::OUT_BITS-1:0]          point_x, point_y;
   logic [pdd_pkg::Z_BITS-1:0]            point_z;

   assign pixel_col = req_tdata[COORD_BITS-1:0];
   assign pixel_row = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign depth_mm  = req_tdata[2*COORD_BITS+DEPTH_BITS-1:2*COORD_BITS];
   assign rsp_tdata = {point_z, point_y, point_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (pdd_pkg::reg_index_type'(csr_addr))
            pdd_pkg::REG_PRINCIPAL_POINT: begin
               cfg_ff.ppx <= csr_wdata[pdd_pkg::PP_BITS-1:0];
               cfg_ff.ppy <= csr_wdata[2*pdd_pkg::PP_BITS-1:pdd_pkg::PP_BITS];
            end
            pdd_pkg::REG_INV_FOCAL_X:   cfg_ff.ifx <= csr_wdata[pdd_pkg::FOCAL_BITS-1:0];
            pdd_pkg::REG_INV_FOCAL_Y:   cfg_ff.ify <= csr_wdata[pdd_pkg::FOCAL_BITS-1:0];
            pdd_pkg::REG_RADIAL_K1:     cfg_ff.k1  <= csr_wdata[CB-1:0];
            pdd_pkg::REG_RADIAL_K2:     cfg_ff.k2  <= csr_wdata[CB-1:0];
            pdd_pkg::REG_RADIAL_K3:     cfg_ff.k3  <= csr_wdata[CB-1:0];
            pdd_pkg::REG_TANGENTIAL_P1: cfg_ff.p1  <= csr_wdata[CB-1:0];
            pdd_pkg::REG_TANGENTIAL_P2: cfg_ff.p2  <= csr_wdata[CB-1:0];
            default: begin
            end
         endcase
      end
   end

   pdd_pipe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .ctrl       (ctrl)
   );

   pdd_normalize #(
      .COORD_BITS (COORD_BITS),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_normalize (
      .clock     (clock),
      .ctrl      (ctrl),
      .cfg       (cfg_ff),
      .pixel_col (pixel_col),
      .pixel_row (pixel_row),
      .depth_mm  (depth_mm),
      .norm_x    (norm_x),
      .norm_y    (norm_y),
      .depth     (depth_n)
   );

   pdd_radial #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_radial (
      .clock   (clock),
      .ctrl    (ctrl),
      .cfg     (cfg_ff),
      .norm_x  (norm_x),
      .norm_y  (norm_y),
      .depth_i (depth_n),
      .x_o     (x_r),
      .y_o     (y_r),
      .xy_o    (xy_r),
      .tx_o    (tx_r),
      .ty_o    (ty_r),
      .fact_o  (fact_r),
      .depth_o (depth_r)
   );

   pdd_correct #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_correct (
      .clock   (clock),
      .ctrl    (ctrl),
      .cfg     (cfg_ff),
      .x_i     (x_r),
      .y_i     (y_r),
      .xy_i    (xy_r),
      .tx_i    (tx_r),
      .ty_i    (ty_r),
      .fact_i  (fact_r),
      .depth_i (depth_r),
      .point_x (point_x),
      .point_y (point_y),
      .point_z (point_z)
   );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     REQ_W        = 40;
   localparam int     QUIET_LIMIT  = 2000;
   localparam int     DRAIN_CYCLES = 2 * (pdd_pkg::PIPE_STAGES + 1);
   localparam int     IDLE_PCT     = 33;
   localparam int     MAX_PRINTED  = 50;
   localparam longint NORM_HI      = 4194303;
   localparam longint NORM_LO      = -4194304;
   localparam longint FACT_HI      = (64'sd1 <<< 31) - 1;
   localparam longint FACT_LO      = -(64'sd1 <<< 31);
   localparam longint OUT_HI       = 8388607;
   localparam longint OUT_LO       = -8388608;

   typedef struct {
      logic [23:0] x;
      logic [23:0] y;
      logic [15:0] z;
   } point_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [REQ_W-1:0]                  req_tdata = '0;   // pixel_col, pixel_row, depth_mm
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pdd_pkg::RSP_BITS-1:0]      rsp_tdata;        // point_x, point_y, point_z
   logic                              csr_we = 1'b0;
   logic [pdd_pkg::CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [pdd_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   pdd_pkg::cfg_type lens = '0;   // register image as seen on the csr port
   point_type        pending_points[$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   bit               steady = 1'b0;      // no idling on either side while set

   pixel_depth_deprojection_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // add half, then floor
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic point_type deproject_pixel(input logic [11:0] col, input logic [11:0] row,
                                                 input logic [15:0] depth);
      longint    dx, dy, x, y, xx, yy, xy, r2, r4, r6, f, ux, uy, dep;
      longint    k1, k2, k3, p1, p2;
      point_type pt;
      k1 = longint'(lens.k1);
      k2 = longint'(lens.k2);
      k3 = longint'(lens.k3);
      p1 = longint'(lens.p1);
      p2 = longint'(lens.p2);
      dx = longint'(col) * 16 - longint'(lens.ppx);
      dy = longint'(row) * 16 - longint'(lens.ppy);
      // Q.4 times Q0.24, down to Q2.20
      x = clamp(round_shift(dx * longint'(lens.ifx), 8), NORM_LO, NORM_HI);
      y = clamp(round_shift(dy * longint'(lens.ify), 8), NORM_LO, NORM_HI);
      xx = round_shift(x * x, 20);
      yy = round_shift(y * y, 20);
      xy = round_shift(x * y, 20);
      r2 = xx + yy;
      r4 = round_shift(r2 * r2, 20);
      r6 = round_shift(r4 * r2, 20);
      f = (64'sd1 <<< 40) + k1 * r2 + k2 * r4 + k3 * r6;
      f = clamp(round_shift(f, 20), FACT_LO, FACT_HI);
      ux = x * f + 2 * p1 * xy + p2 * (r2 + 2 * xx);
      uy = y * f + 2 * p2 * xy + p1 * (r2 + 2 * yy);
      ux = clamp(round_shift(ux, 20), NORM_LO, NORM_HI);
      uy = clamp(round_shift(uy, 20), NORM_LO, NORM_HI);
      dep = longint'(depth);
      pt.x = 24'(clamp(round_shift(dep * ux, 16), OUT_LO, OUT_HI));
      pt.y = 24'(clamp(round_shift(dep * uy, 16), OUT_LO, OUT_HI));
      pt.z = depth;
      return pt;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      point_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_addr)
               pdd_pkg::REG_PRINCIPAL_POINT: begin
                  lens.ppx = csr_wdata[15:0];
                  lens.ppy = csr_wdata[31:16];
               end
               pdd_pkg::REG_INV_FOCAL_X:   lens.ifx = csr_wdata[23:0];
               pdd_pkg::REG_INV_FOCAL_Y:   lens.ify = csr_wdata[23:0];
               pdd_pkg::REG_RADIAL_K1:     lens.k1 = csr_wdata[23:0];
               pdd_pkg::REG_RADIAL_K2:     lens.k2 = csr_wdata[23:0];
               pdd_pkg::REG_RADIAL_K3:     lens.k3 = csr_wdata[23:0];
               pdd_pkg::REG_TANGENTIAL_P1: lens.p1 = csr_wdata[23:0];
               pdd_pkg::REG_TANGENTIAL_P2: lens.p2 = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_points.size() == 0) begin
               report_mismatch($sformatf("result item with none expected: %h", rsp_tdata));
            end else begin
               want = pending_points.pop_front();
               if (rsp_tdata[23:0] !== want.x)
                  report_mismatch($sformatf("point_x got %0d expected %0d",
                                            $signed(rsp_tdata[23:0]), $signed(want.x)));
               if (rsp_tdata[47:24] !== want.y)
                  report_mismatch($sformatf("point_y got %0d expected %0d",
                                            $signed(rsp_tdata[47:24]), $signed(want.y)));
               if (rsp_tdata[63:48] !== want.z)
                  report_mismatch($sformatf("point_z got %0d expected %0d",
                                            rsp_tdata[63:48], want.z));
            end
         end
         if (req_tvalid && req_tready)
            pending_points.push_back(deproject_pixel(req_tdata[11:0], req_tdata[23:12],
                                                     req_tdata[39:24]));
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL pixel_depth_deprojection_core");
            $finish;
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

   // ---------------------------------------------------------------- stimulus

   // valid stays high from one item to the next unless the sender idles
   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                             input logic [15:0] depth);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {depth, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic csr_write(input pdd_pkg::reg_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_lens(input pdd_pkg::cfg_type c);
      wait_drained();
      csr_write(pdd_pkg::REG_PRINCIPAL_POINT, {c.ppy, c.ppx});
      csr_write(pdd_pkg::REG_INV_FOCAL_X, {8'h00, c.ifx});
      csr_write(pdd_pkg::REG_INV_FOCAL_Y, {8'h00, c.ify});
      csr_write(pdd_pkg::REG_RADIAL_K1, {8'h00, c.k1});
      csr_write(pdd_pkg::REG_RADIAL_K2, {8'h00, c.k2});
      csr_write(pdd_pkg::REG_RADIAL_K3, {8'h00, c.k3});
      csr_write(pdd_pkg::REG_TANGENTIAL_P1, {8'h00, c.p1});
      csr_write(pdd_pkg::REG_TANGENTIAL_P2, {8'h00, c.p2});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pdd_pkg::cfg_type pinhole(input logic [15:0] ppx, input logic [15:0] ppy,
                                                input logic [23:0] ifx, input logic [23:0] ify);
      pdd_pkg::cfg_type c;
      c = '0;
      c.ppx = ppx;
      c.ppy = ppy;
      c.ifx = ifx;
      c.ify = ify;
      return c;
   endfunction

   // plausible camera: focal length in pixels, centre somewhere in the sensor
   function automatic pdd_pkg::cfg_type lens_realistic(input int unsigned spread);
      pdd_pkg::cfg_type c;
      c = pinhole(16'($urandom_range(100 * 16, 3000 * 16)),
                  16'($urandom_range(100 * 16, 3000 * 16)),
                  24'((32'd1 << 24) / $urandom_range(200, 3000)),
                  24'((32'd1 << 24) / $urandom_range(200, 3000)));
      c.k1 = 24'($urandom_range(0, 2 * spread) - spread);
      c.k2 = 24'($urandom_range(0, 2 * spread) - spread);
      c.k3 = 24'($urandom_range(0, 2 * spread) - spread);
      c.p1 = 24'($urandom_range(0, 2 * spread) - spread);
      c.p2 = 24'($urandom_range(0, 2 * spread) - spread);
      return c;
   endfunction

   function automatic pdd_pkg::cfg_type lens_random();
      pdd_pkg::cfg_type c;
      c = pinhole(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
      c.k1 = 24'($urandom);
      c.k2 = 24'($urandom);
      c.k3 = 24'($urandom);
      c.p1 = 24'($urandom);
      c.p2 = 24'($urandom);
      return c;
   endfunction

   function automatic logic [11:0] pick_coord(input logic [15:0] centre_q4);
      int v;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         1, 2, 3, 4: return 12'($urandom);
         default: begin
            v = int'(centre_q4 >> 4) + int'($urandom_range(0, 800)) - 400;
            return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
         end
      endcase
   endfunction

   task automatic send_random_pixel();
      logic [11:0] col, row;
      logic [15:0] depth;
      col = pick_coord(lens.ppx);
      row = pick_coord(lens.ppy);
      case ($urandom_range(0, 3))
         0: depth = 16'($urandom_range(0, 4000));
         1: depth = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: depth = 16'($urandom);
      endcase
      send_pixel(col, row, depth);
   endtask

   // ---------------------------------------------------------------- tests

   // all registers zero: every point lands on the optical axis
   task automatic test_reset_defaults();
      send_pixel(12'd0, 12'd0, 16'd0);
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      send_pixel(12'd1234, 12'd567, 16'd1000);
   endtask

   task automatic test_pinhole();
      // centre at column 320, row 240 in Q12.4
      program_lens(pinhole(16'd5120, 16'd3840, 24'd27962, 24'd27962));
      send_pixel(12'd0, 12'd0, 16'd1000);
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      send_pixel(12'd320, 12'd240, 16'd500);
      send_pixel(12'd639, 12'd0, 16'd0);
      send_pixel(12'd0, 12'd479, 16'd1);
      // centre past the sensor, huge scale: normalized coords clip negative
      program_lens(pinhole(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF));
      send_pixel(12'd0, 12'd0, 16'hFFFF);
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      // clip positive at the far corner
      program_lens(pinhole(16'h0000, 16'h0000, 24'hFF_FFFF, 24'hFF_FFFF));
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      send_pixel(12'd1, 12'd1, 16'hFFFF);
   endtask

   task automatic test_distortion();
      pdd_pkg::cfg_type c;
      c = pinhole(16'd5120, 16'd3840, 24'd27962, 24'd27962);
      c.k1 = -24'sd293601;
      c.k2 = 24'sd73400;
      c.k3 = -24'sd10486;
      c.p1 = 24'sd1049;
      c.p2 = -24'sd524;
      program_lens(c);
      send_pixel(12'd0, 12'd0, 16'd2000);
      send_pixel(12'd639, 12'd479, 16'd2000);
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      // distortion factor and corrected coords run into their limits
      c = pinhole(16'h0000, 16'h0000, 24'hFF_FFFF, 24'hFF_FFFF);
      c.k1 = 24'h7F_FFFF;
      c.k2 = 24'h7F_FFFF;
      c.k3 = 24'h7F_FFFF;
      c.p1 = 24'h7F_FFFF;
      c.p2 = 24'h7F_FFFF;
      program_lens(c);
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      send_pixel(12'd1, 12'd2, 16'hFFFF);
      c.k1 = 24'h80_0000;
      c.k2 = 24'h80_0000;
      c.k3 = 24'h80_0000;
      c.p1 = 24'h80_0000;
      c.p2 = 24'h80_0000;
      program_lens(c);
      send_pixel(12'd4095, 12'd0, 16'hFFFF);
      send_pixel(12'd0, 12'd4095, 16'hFFFF);
   endtask

   task automatic test_random_traffic();
      pdd_pkg::cfg_type c;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0, 1: c = lens_realistic(32'd1 << 19);
            2: c = lens_random();
            3: c = lens_realistic(32'h7F_FFFF);
            4: begin
               c = lens_random();
               c.k1 = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
               c.k2 = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
               c.k3 = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
               c.p1 = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
               c.p2 = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
            end
            default: c = pinhole(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
         endcase
         program_lens(c);
         steady = (phase == 0);
         for (int n = 0; n < 250; n++) begin
            // let the pipeline run dry once in the middle of a stream
            if (phase == 1 && n == 125)
               wait_drained();
            send_random_pixel();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_pinhole();
      test_distortion();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS pixel_depth_deprojection_core");
      else
         $display("FAIL pixel_depth_deprojection_core");
      $finish;
   end

endmodule

`default_nettype wire
